FILE: rtl/bqa_pkg.sv
package bqa_pkg;

    localparam int LANES      = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_AMAX = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AMAX_SEED      = 8'd1;

    // fp32 constants
    localparam logic [31:0] FP32_INF  = 32'h7F80_0000;
    localparam logic [31:0] FP32_QNAN = 32'h7FC0_0000;
    // 1e-8f, added to the reference amax
    localparam logic [7:0]  EPS_EXP   = 8'd100;
    localparam logic [23:0] EPS_MANT  = 24'hAB_CC77;
    // 448.0f as numerator of the scale
    localparam logic [23:0] NUM_MANT  = 24'hE0_0000;
    localparam logic [9:0]  NUM_QEXP  = 10'd262;
    // e4m3 saturation magnitude code (448)
    localparam logic [6:0]  E4M3_MAX  = 7'h7E;

    typedef enum logic [2:0] {
        SC_IDLE,
        SC_ALIGN,
        SC_SUM,
        SC_NORM,
        SC_ROUND,
        SC_DIV,
        SC_DIV_ROUND
    } t_scale_state;

    typedef struct packed {
        logic        start;
        logic [31:0] operand;
    } t_scale_req;

    typedef struct packed {
        logic        busy;
        logic [31:0] scale;
    } t_scale_rsp;

endpackage

FILE: rtl/bqa_if.sv
interface bqa_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] value_0;
    logic [15:0] value_1;
    logic [15:0] value_2;
    logic [15:0] value_3;
    logic [15:0] value_4;
    logic [15:0] value_5;
    logic [15:0] value_6;
    logic [15:0] value_7;
    logic        last_in;

    modport source (
        output valid, value_0, value_1, value_2, value_3,
               value_4, value_5, value_6, value_7, last_in,
        input  ready
    );
    modport sink (
        input  valid, value_0, value_1, value_2, value_3,
               value_4, value_5, value_6, value_7, last_in,
        output ready
    );
endinterface

interface bqa_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  code_0;
    logic [7:0]  code_1;
    logic [7:0]  code_2;
    logic [7:0]  code_3;
    logic [7:0]  code_4;
    logic [7:0]  code_5;
    logic [7:0]  code_6;
    logic [7:0]  code_7;
    logic [30:0] running_amax;
    logic        last_out;

    modport source (
        output valid, code_0, code_1, code_2, code_3, code_4, code_5,
               code_6, code_7, running_amax, last_out,
        input  ready
    );
    modport sink (
        input  valid, code_0, code_1, code_2, code_3, code_4, code_5,
               code_6, code_7, running_amax, last_out,
        output ready
    );
endinterface

interface bqa_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [bqa_pkg::CFG_IDX_W-1:0]    index;
    logic [bqa_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/bqa_lane.sv
module bqa_lane (
    input  logic [15:0] i_value,
    input  logic [31:0] i_scale,
    output logic [7:0]  o_code,
    output logic [14:0] o_mag
);

    logic               sv, ss, sgn;
    logic [7:0]         ev, es, evf, esf;
    logic [6:0]         fv;
    logic [22:0]        fs;
    logic               v_nan, v_inf, v_zero, s_nan, s_inf, s_zero;
    logic [7:0]         mv, mvn;
    logic [2:0]         lzv;
    logic [23:0]        ms;
    logic [31:0]        prod, pn;
    logic signed [10:0] xe, xr;
    logic [23:0]        m24, mr;
    logic [24:0]        m25;
    logic               up;
    logic [6:0]         base;
    logic [7:0]         nrm;
    logic [4:0]         sh;
    logic [23:0]        rem, half;
    logic [7:0]         q, mag_code;

    always_comb begin
        sv = i_value[15];
        ev = i_value[14:7];
        fv = i_value[6:0];
        ss = i_scale[31];
        es = i_scale[30:23];
        fs = i_scale[22:0];
        sgn = sv ^ ss;

        v_nan  = (ev == 8'hFF) && (fv != 7'd0);
        v_inf  = (ev == 8'hFF) && (fv == 7'd0);
        v_zero = (ev == 8'h00) && (fv == 7'd0);
        s_nan  = (es == 8'hFF) && (fs != 23'd0);
        s_inf  = (es == 8'hFF) && (fs == 23'd0);
        s_zero = (es == 8'h00) && (fs == 23'd0);

        // normalize the bf16 significand first so the product needs no wide search
        evf = (ev == 8'h00) ? 8'd1 : ev;
        esf = (es == 8'h00) ? 8'd1 : es;
        mv  = {ev != 8'h00, fv};
        lzv = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (mv[i]) begin
                lzv = 3'(7 - i);
            end
        end
        mvn  = mv << lzv;
        ms   = {es != 8'h00, fs};
        prod = 32'(mvn) * 32'(ms);

        xe = $signed(11'(evf) - 11'(lzv) + 11'(esf) - 11'd254 + 11'(prod[31]));
        pn = prod[31] ? prod : {prod[30:0], 1'b0};

        // round the product to fp32
        m24 = pn[31:8];
        up  = pn[7] & ((|pn[6:0]) | m24[0]);
        m25 = {1'b0, m24} + 25'(up);
        if (m25[24]) begin
            mr = m25[24:1];
            xr = xe + 11'sd1;
        end else begin
            mr = m25[23:0];
            xr = xe;
        end

        // e4m3 normal range
        base = {4'(xr + 11'sd7), mr[22:20]};
        nrm  = {1'b0, base} + 8'(mr[19] & ((|mr[18:0]) | base[0]));

        // e4m3 subnormal range, units of 2^-9
        sh   = 5'(11'sd14 - xr);
        q    = 8'(mr >> sh);
        rem  = mr & ((24'd1 << sh) - 24'd1);
        half = 24'd1 << (sh - 5'd1);

        if ((xr > 11'sd8) || ((xr == 11'sd8) && (mr > bqa_pkg::NUM_MANT))) begin
            mag_code = {1'b0, bqa_pkg::E4M3_MAX};
        end else if (xr >= -11'sd6) begin
            mag_code = (nrm > {1'b0, bqa_pkg::E4M3_MAX}) ? {1'b0, bqa_pkg::E4M3_MAX} : nrm;
        end else if (xr >= -11'sd10) begin
            mag_code = q + 8'((rem > half) || ((rem == half) && q[0]));
        end else begin
            mag_code = 8'd0;
        end

        priority if (v_nan || s_nan || (v_inf && s_zero) || (s_inf && v_zero)) begin
            o_code = {1'b0, bqa_pkg::E4M3_MAX};
        end else if (v_inf || s_inf) begin
            o_code = {sgn, bqa_pkg::E4M3_MAX};
        end else if (v_zero || s_zero) begin
            o_code = {sgn, 7'd0};
        end else begin
            o_code = {sgn, mag_code[6:0]};
        end

        // nan never enters the running max
        o_mag = (i_value[14:0] <= 15'h7F80) ? i_value[14:0] : 15'd0;
    end

endmodule

FILE: rtl/bqa_scale_unit.sv
module bqa_scale_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bqa_pkg::t_scale_req i_req,
    output bqa_pkg::t_scale_rsp o_rsp
);

    bqa_pkg::t_scale_state r_state, n_state;

    logic [31:0] r_op;
    logic [26:0] r_big, r_small;
    logic [27:0] r_sum;
    logic [8:0]  r_exp;
    logic        r_sign, r_sub;
    logic [23:0] r_den;
    logic [9:0]  r_qexp;
    logic [25:0] r_rem;
    logic [24:0] r_quo;
    logic [4:0]  r_cnt;
    logic [31:0] r_scale;

    // alignment of the operand against the epsilon
    logic        op_special;
    logic [7:0]  ea, e_l, e_s, d;
    logic [23:0] ma, m_l, m_s;
    logic        a_big;
    logic [26:0] ext, shd, aligned_s;
    logic        st;

    // rounding of the sum and of the quotient
    logic [24:0] rd_m25, dv_m25;
    logic [8:0]  rd_exp;
    logic [23:0] rd_mant, dv_mant;
    logic [9:0]  dv_exp;
    logic        den_inf;

    always_comb begin
        op_special = (r_op[30:23] == 8'hFF);
        ea = (r_op[30:23] == 8'h00) ? 8'd1 : r_op[30:23];
        ma = {r_op[30:23] != 8'h00, r_op[22:0]};
        a_big = {ea, ma} >= {bqa_pkg::EPS_EXP, bqa_pkg::EPS_MANT};
        e_l = a_big ? ea : bqa_pkg::EPS_EXP;
        m_l = a_big ? ma : bqa_pkg::EPS_MANT;
        e_s = a_big ? bqa_pkg::EPS_EXP : ea;
        m_s = a_big ? bqa_pkg::EPS_MANT : ma;
        d   = e_l - e_s;
        ext = {m_s, 3'b000};
        if (d >= 8'd27) begin
            shd = 27'd0;
            st  = |m_s;
        end else begin
            shd = ext >> d;
            st  = |(ext & ((27'd1 << d) - 27'd1));
        end
        aligned_s = {shd[26:1], shd[0] | st};

        rd_m25 = {1'b0, r_sum[26:3]}
               + 25'(r_sum[2] & (r_sum[1] | r_sum[0] | r_sum[3]));
        rd_exp  = r_exp + 9'(rd_m25[24]);
        rd_mant = rd_m25[24] ? rd_m25[24:1] : rd_m25[23:0];
        den_inf = (rd_exp >= 9'd255);

        dv_m25  = {1'b0, r_quo[24:1]}
                + 25'(r_quo[0] & ((r_rem != 26'd0) | r_quo[1]));
        dv_mant = dv_m25[24] ? dv_m25[24:1] : dv_m25[23:0];
        dv_exp  = r_qexp + 10'(dv_m25[24]);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bqa_pkg::SC_IDLE: begin
                if (i_req.start) n_state = bqa_pkg::SC_ALIGN;
            end
            bqa_pkg::SC_ALIGN: begin
                n_state = op_special ? bqa_pkg::SC_IDLE : bqa_pkg::SC_SUM;
            end
            bqa_pkg::SC_SUM: begin
                n_state = bqa_pkg::SC_NORM;
            end
            bqa_pkg::SC_NORM: begin
                priority if (r_sum == 28'd0) begin
                    n_state = bqa_pkg::SC_IDLE;
                end else if (r_sum[27] || r_sum[26] || (r_exp <= 9'd1)) begin
                    n_state = bqa_pkg::SC_ROUND;
                end else begin
                    n_state = bqa_pkg::SC_NORM;
                end
            end
            bqa_pkg::SC_ROUND: begin
                n_state = den_inf ? bqa_pkg::SC_IDLE : bqa_pkg::SC_DIV;
            end
            bqa_pkg::SC_DIV: begin
                if (r_cnt == 5'd1) n_state = bqa_pkg::SC_DIV_ROUND;
            end
            bqa_pkg::SC_DIV_ROUND: begin
                n_state = bqa_pkg::SC_IDLE;
            end
            default: n_state = bqa_pkg::SC_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_rsp.busy  = (r_state != bqa_pkg::SC_IDLE);
        o_rsp.scale = r_scale;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bqa_pkg::SC_ALIGN;
            r_op    <= 32'd0;
        end else begin
            r_state <= n_state;
            if ((r_state == bqa_pkg::SC_IDLE) && i_req.start) begin
                r_op <= i_req.operand;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            bqa_pkg::SC_ALIGN: begin
                if (op_special) begin
                    // nan stays nan, infinity gives a signed zero scale
                    r_scale <= (r_op[22:0] != 23'd0) ? bqa_pkg::FP32_QNAN
                                                     : {r_op[31], 31'd0};
                end
                r_big   <= {m_l, 3'b000};
                r_small <= aligned_s;
                r_exp   <= {1'b0, e_l};
                r_sign  <= a_big ? r_op[31] : 1'b0;
                r_sub   <= r_op[31];
            end
            bqa_pkg::SC_SUM: begin
                r_sum <= r_sub ? ({1'b0, r_big} - {1'b0, r_small})
                               : ({1'b0, r_big} + {1'b0, r_small});
            end
            bqa_pkg::SC_NORM: begin
                priority if (r_sum == 28'd0) begin
                    // exact cancellation: zero denominator
                    r_scale <= bqa_pkg::FP32_INF;
                end else if (r_sum[27]) begin
                    r_sum <= {1'b0, r_sum[27:2], r_sum[1] | r_sum[0]};
                    r_exp <= r_exp + 9'd1;
                end else if (!r_sum[26] && (r_exp > 9'd1)) begin
                    r_sum <= {r_sum[26:0], 1'b0};
                    r_exp <= r_exp - 9'd1;
                end
            end
            bqa_pkg::SC_ROUND: begin
                if (den_inf) begin
                    r_scale <= {r_sign, 31'd0};
                end
                r_den <= rd_mant;
                r_quo <= 25'd0;
                r_cnt <= 5'd25;
                if (bqa_pkg::NUM_MANT < rd_mant) begin
                    r_rem  <= {1'b0, bqa_pkg::NUM_MANT, 1'b0};
                    r_qexp <= bqa_pkg::NUM_QEXP - 10'd1 - {1'b0, rd_exp};
                end else begin
                    r_rem  <= {2'b00, bqa_pkg::NUM_MANT};
                    r_qexp <= bqa_pkg::NUM_QEXP - {1'b0, rd_exp};
                end
            end
            bqa_pkg::SC_DIV: begin
                // restoring division, one quotient bit a cycle
                if (r_rem >= {2'b00, r_den}) begin
                    r_quo <= {r_quo[23:0], 1'b1};
                    r_rem <= {r_rem[24:0] - {1'b0, r_den}, 1'b0};
                end else begin
                    r_quo <= {r_quo[23:0], 1'b0};
                    r_rem <= {r_rem[24:0], 1'b0};
                end
                r_cnt <= r_cnt - 5'd1;
            end
            bqa_pkg::SC_DIV_ROUND: begin
                r_scale <= {r_sign, dv_exp[7:0], dv_mant[22:0]};
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: rtl/bf16_to_fp8_quantize_amax_core.sv
// bf16 to fp8 e4m3 quantizer with running absolute maximum
//
// i_in carries eight bfloat16 lane values and a last flag; o_out returns the
// eight e4m3 codes, the running amax (fp32 bits) and the copied last flag.
// i_cfg writes reference_amax (index 0) and amax_seed (index 1); other
// indexes are dropped.
// an accepted item waits in the input register and moves to the result
// register when that is free or being emptied, raising o_out.valid; one item
// per cycle sustained while o_out.ready is high and the scale unit is idle.
// the lane multiply, fp32 rounding and e4m3 rounding are one combinational
// pass between those two registers. writing reference_amax starts the scale
// unit (fp32 add of 1e-8 with an iterative normalize, then a 25-step
// restoring divide into 448); it is busy through align, sum, normalize, round
// and divide for a finite reference (the normalize runs longest after a near
// cancellation), through normalize when the sum cancels to zero and through
// align for an infinite or nan reference, and holds i_in.ready and i_cfg.ready
// low meanwhile. reset clears the valid flags, seed and running max and runs
// that same scale computation for a reference amax of zero, so i_in.ready
// stays low until it ends. when o_out.ready is low the result register holds,
// the input register still fills, then i_in.ready drops until the result is taken.
module bf16_to_fp8_quantize_amax_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bqa_in_if.sink       i_in,
    bqa_out_if.source    o_out,
    bqa_cfg_if.sink      i_cfg
);

    localparam int L = bqa_pkg::LANES;

    // scale unit
    bqa_pkg::t_scale_req scale_req;
    bqa_pkg::t_scale_rsp scale_rsp;

    // configuration
    logic        cfg_fire;
    logic [30:0] r_seed;
    logic [30:0] seed_clean;

    // input register
    logic              r_in_vld;
    logic [15:0]       r_val [L];
    logic              r_in_last;
    logic [15:0]       in_val [L];
    logic              in_fire, adv;

    // lanes and running max
    logic [7:0]  lane_code [L];
    logic [14:0] lane_mag [L];
    logic [14:0] lane_max;
    logic [30:0] amax_new;
    logic [30:0] r_max;

    // result register
    logic        r_out_vld;
    logic [7:0]  r_code [L];
    logic [30:0] r_amax;
    logic        r_last;

    // config port is held off while the scale is being derived
    assign i_cfg.ready = !scale_rsp.busy;
    assign cfg_fire    = i_cfg.valid && i_cfg.ready;

    assign scale_req.start   = cfg_fire && (i_cfg.index == bqa_pkg::REG_REFERENCE_AMAX);
    assign scale_req.operand = i_cfg.data;

    bqa_scale_unit u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (scale_req),
        .o_rsp   (scale_rsp)
    );

    // a nan seed pattern counts as zero
    function automatic logic [30:0] clean_seed(input logic [30:0] s);
        return ({1'b0, s} > bqa_pkg::FP32_INF) ? 31'd0 : s;
    endfunction

    assign seed_clean = clean_seed(i_cfg.data[30:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= 31'd0;
        end else if (cfg_fire && (i_cfg.index == bqa_pkg::REG_AMAX_SEED)) begin
            r_seed <= i_cfg.data[30:0];
        end
    end

    // item moves forward when the result register is free or being emptied
    assign adv         = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready  = !scale_rsp.busy && (!r_in_vld || adv);
    assign in_fire     = i_in.valid && i_in.ready;

    always_comb begin
        in_val[0] = i_in.value_0;
        in_val[1] = i_in.value_1;
        in_val[2] = i_in.value_2;
        in_val[3] = i_in.value_3;
        in_val[4] = i_in.value_4;
        in_val[5] = i_in.value_5;
        in_val[6] = i_in.value_6;
        in_val[7] = i_in.value_7;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_fire) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_val     <= in_val;
            r_in_last <= i_in.last_in;
        end
    end

    // one quantizer per lane
    for (genvar g = 0; g < L; g++) begin : g_lane
        bqa_lane u_lane (
            .i_value (r_val[g]),
            .i_scale (scale_rsp.scale),
            .o_code  (lane_code[g]),
            .o_mag   (lane_mag[g])
        );
    end

    // max of the lane magnitudes, merged with the running max
    always_comb begin
        lane_max = 15'd0;
        for (int i = 0; i < L; i++) begin
            if (lane_mag[i] > lane_max) begin
                lane_max = lane_mag[i];
            end
        end
        amax_new = ({lane_max, 16'd0} > r_max) ? {lane_max, 16'd0} : r_max;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= 31'd0;
        end else if (cfg_fire && (i_cfg.index == bqa_pkg::REG_AMAX_SEED)) begin
            r_max <= seed_clean;
        end else if (adv) begin
            // reload from the seed once a tensor closes
            r_max <= r_in_last ? clean_seed(r_seed) : amax_new;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_code <= lane_code;
            r_amax <= amax_new;
            r_last <= r_in_last;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.code_0       = r_code[0];
    assign o_out.code_1       = r_code[1];
    assign o_out.code_2       = r_code[2];
    assign o_out.code_3       = r_code[3];
    assign o_out.code_4       = r_code[4];
    assign o_out.code_5       = r_code[5];
    assign o_out.code_6       = r_code[6];
    assign o_out.code_7       = r_code[7];
    assign o_out.running_amax = r_amax;
    assign o_out.last_out     = r_last;

endmodule
